// ===== rtl/sfdi_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the stereo feedback delay with interpolated read.
// Used by sfdi_smul and stereo_feedback_delay_interp; depends on nothing.
package sfdi_pkg;

    localparam int DELAY_AW     = 19;
    localparam int MAX_DELAY    = 2 ** DELAY_AW;
    localparam int CH_W         = 3;
    localparam int MAX_CHANNELS = 2 ** CH_W;
    localparam int LINES        = 2;
    localparam int MEM_AW       = DELAY_AW + 1;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int DELAY_W  = 27;
    localparam int FRAC_W   = 8;
    localparam int MCAND_W  = 32;
    localparam int MPLIER_W = GAIN_W;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int CNT_W    = $clog2(MPLIER_W);

    localparam logic [GAIN_W-1:0]  FEEDBACK_CAP   = 16'd64880;
    localparam logic [DELAY_W-1:0] DELAY_RESET    = 27'd61440;
    localparam logic [GAIN_W-1:0]  FEEDBACK_RESET = 16'd0;
    localparam logic [GAIN_W-1:0]  DRY_RESET      = 16'd8192;
    localparam logic [GAIN_W-1:0]  WET_RESET      = 16'd8192;

    typedef enum logic [1:0] {
        CFG_DELAY    = 2'd0,
        CFG_FEEDBACK = 2'd1,
        CFG_DRY      = 2'd2,
        CFG_WET      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

endpackage

// ===== rtl/stereo_feedback_delay_interp.sv =====
`timescale 1ns / 1ps
// Top level of the stereo feedback delay with linearly interpolated fractional read.
// Uses sfdi_pkg and three sfdi_smul bit-serial multipliers.
//
// Usage: an item on the s_axis channel carries one sample in tdata and its channel index
// in tuser. Channels 0 and 1 each own a circular delay line of MAX_DELAY entries held in
// one shared single-port-read memory; other channels get the dry gain only. The m_axis
// channel returns exactly one item per input item, in order.
// The cfg channel writes the four gain and delay registers; o_cfg_ready is always high,
// and writes are meant to happen while no item is in flight.
// From acceptance until m_axis_tvalid rises, an item passes through two memory reads, a load
// and 16 steps of the interpolation multiply, a load and 16 steps of the three gain
// multipliers, a step to sum, saturate and write back, and a step to fill the output
// register. Items are taken one at a time, each once the last reaches the output register.
// A finished item waits in the output register while the next item is accepted; the
// block holds its last step only if that register is still full.
// Reset clears the pointers and control state and loads the register defaults. The delay
// lines need no clearing pass: an entry not yet written since reset reads as zero, decided
// from the write pointer and a wrap flag per line.
module stereo_feedback_delay_interp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sfdi_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [23:0] sample_in
    input  logic [sfdi_pkg::CH_W-1:0]           s_axis_tuser,  // [2:0] channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sfdi_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [23:0] sample_out
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [sfdi_pkg::DELAY_W-1:0]        i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_RD_PREV = 9'b000000010,
        S_RD_NEXT = 9'b000000100,
        S_LOAD_I  = 9'b000001000,
        S_MUL_I   = 9'b000010000,
        S_LOAD_G  = 9'b000100000,
        S_MUL_G   = 9'b001000000,
        S_FIN     = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    localparam logic [sfdi_pkg::CNT_W-1:0] CNT_LAST = sfdi_pkg::CNT_W'(sfdi_pkg::MPLIER_W - 1);

    function automatic logic signed [sfdi_pkg::SAMPLE_W-1:0] sat24(input logic signed [27:0] v);
        logic signed [27:0] hi_lim;
        logic signed [27:0] lo_lim;
        hi_lim = 28'sd8388607;
        lo_lim = -28'sd8388608;
        if (v > hi_lim) begin
            return 24'sh7FFFFF;
        end else if (v < lo_lim) begin
            return 24'sh800000;
        end
        return v[sfdi_pkg::SAMPLE_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [sfdi_pkg::DELAY_W-1:0] r_delay;
    logic [sfdi_pkg::GAIN_W-1:0]  r_fb;
    logic [sfdi_pkg::GAIN_W-1:0]  r_dry;
    logic [sfdi_pkg::GAIN_W-1:0]  r_wet;
    logic [sfdi_pkg::GAIN_W-1:0]  fb_capped;

    logic [sfdi_pkg::LINES-1:0][sfdi_pkg::DELAY_AW-1:0] r_wp;
    logic [sfdi_pkg::LINES-1:0]                         r_wrap;

    logic signed [sfdi_pkg::SAMPLE_W-1:0] r_line_mem [2 ** sfdi_pkg::MEM_AW];
    logic signed [sfdi_pkg::SAMPLE_W-1:0] r_rdata;

    logic signed [sfdi_pkg::SAMPLE_W-1:0] r_x;
    logic                                 r_line;
    logic                                 r_is_line;
    logic [sfdi_pkg::DELAY_AW-1:0]        r_prev_addr;
    logic [sfdi_pkg::DELAY_AW-1:0]        r_next_addr;
    logic                                 r_pv;
    logic                                 r_nv;
    logic [sfdi_pkg::FRAC_W-1:0]          r_frac;
    logic signed [sfdi_pkg::SAMPLE_W-1:0] r_prev_s;
    logic [sfdi_pkg::CNT_W-1:0]           r_cnt;
    logic signed [sfdi_pkg::SAMPLE_W-1:0] r_y;
    logic [sfdi_pkg::SAMPLE_W-1:0]        r_out_data;
    logic                                 r_out_valid;

    logic                          in_fire;
    logic                          slot_free;
    logic                          acc_line;
    logic [sfdi_pkg::DELAY_AW-1:0] acc_wp;
    logic [sfdi_pkg::FRAC_W-1:0]   acc_dfrac;
    logic [sfdi_pkg::DELAY_AW-1:0] acc_prev;
    logic [sfdi_pkg::DELAY_AW-1:0] acc_next;

    logic                          rd_en;
    logic [sfdi_pkg::MEM_AW-1:0]   rd_addr;
    logic                          wr_en;
    logic [sfdi_pkg::MEM_AW-1:0]   wr_addr;

    logic signed [sfdi_pkg::SAMPLE_W-1:0] next_s;
    logic signed [sfdi_pkg::SAMPLE_W:0]   diff;
    logic signed [sfdi_pkg::MCAND_W-1:0]  e_val;

    sfdi_pkg::t_mul_ctl ctl_fb, ctl_dry, ctl_wet;
    logic signed [sfdi_pkg::MCAND_W-1:0] wet_mcand;
    logic [sfdi_pkg::MPLIER_W-1:0]       wet_mplier;
    logic signed [sfdi_pkg::MCAND_W-1:0] dry_mcand;
    logic signed [sfdi_pkg::PROD_W-1:0]  fb_prod, dry_prod, wet_prod;

    logic signed [sfdi_pkg::PROD_W-1:0]   fb_round;
    logic signed [sfdi_pkg::SAMPLE_W-1:0] fb_term;
    logic signed [27:0]                   store_sum;
    logic signed [sfdi_pkg::SAMPLE_W-1:0] store_val;
    logic signed [sfdi_pkg::PROD_W:0]     acc_sum;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign fb_capped = (r_fb > sfdi_pkg::FEEDBACK_CAP) ? sfdi_pkg::FEEDBACK_CAP : r_fb;

    // Read position: write pointer minus the integer delay, one further back when the
    // delay has a fraction; the weight of the newer entry is 256 minus the fraction, or 0 without one.
    assign acc_line  = s_axis_tuser[0];
    assign acc_wp    = r_wp[acc_line];
    assign acc_dfrac = r_delay[sfdi_pkg::FRAC_W-1:0];
    assign acc_prev  = acc_wp - r_delay[sfdi_pkg::FRAC_W +: sfdi_pkg::DELAY_AW]
                       - sfdi_pkg::DELAY_AW'(|acc_dfrac);
    assign acc_next  = acc_prev + sfdi_pkg::DELAY_AW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_fire) n_state = S_RD_PREV;
            S_RD_PREV: n_state = S_RD_NEXT;
            S_RD_NEXT: n_state = S_LOAD_I;
            S_LOAD_I:  n_state = S_MUL_I;
            S_MUL_I:   if (r_cnt == CNT_LAST) n_state = S_LOAD_G;
            S_LOAD_G:  n_state = S_MUL_G;
            S_MUL_G:   if (r_cnt == CNT_LAST) n_state = S_FIN;
            S_FIN:     n_state = S_OUT;
            S_OUT:     if (slot_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= sfdi_pkg::DELAY_RESET;
            r_fb    <= sfdi_pkg::FEEDBACK_RESET;
            r_dry   <= sfdi_pkg::DRY_RESET;
            r_wet   <= sfdi_pkg::WET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (sfdi_pkg::t_cfg_idx'(i_cfg_index))
                sfdi_pkg::CFG_DELAY:    r_delay <= i_cfg_data;
                sfdi_pkg::CFG_FEEDBACK: r_fb    <= i_cfg_data[sfdi_pkg::GAIN_W-1:0];
                sfdi_pkg::CFG_DRY:      r_dry   <= i_cfg_data[sfdi_pkg::GAIN_W-1:0];
                sfdi_pkg::CFG_WET:      r_wet   <= i_cfg_data[sfdi_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x         <= $signed(s_axis_tdata);
            r_line      <= acc_line;
            r_is_line   <= (s_axis_tuser[sfdi_pkg::CH_W-1:1] == '0);
            r_prev_addr <= acc_prev;
            r_next_addr <= acc_next;
            r_pv        <= (s_axis_tuser[sfdi_pkg::CH_W-1:1] == '0)
                           && (r_wrap[acc_line] || (acc_prev < acc_wp));
            r_nv        <= (s_axis_tuser[sfdi_pkg::CH_W-1:1] == '0)
                           && (r_wrap[acc_line] || (acc_next < acc_wp));
            r_frac      <= sfdi_pkg::FRAC_W'(0) - acc_dfrac;
        end
        if (r_state == S_RD_NEXT) begin
            r_prev_s <= r_pv ? r_rdata : '0;
        end
    end

    assign rd_en   = (r_state == S_RD_PREV) || (r_state == S_RD_NEXT);
    assign rd_addr = {r_line, (r_state == S_RD_PREV) ? r_prev_addr : r_next_addr};
    assign wr_en   = (r_state == S_FIN) && r_is_line;
    assign wr_addr = {r_line, r_wp[r_line]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[wr_addr] <= store_val;
        end
        if (rd_en) begin
            r_rdata <= r_line_mem[rd_addr];
        end
    end

    // The interpolation is prev * 256 + (next - prev) * frac, on the wet multiplier.
    assign next_s = r_nv ? r_rdata : '0;
    assign diff   = {next_s[sfdi_pkg::SAMPLE_W-1], next_s}
                    - {r_prev_s[sfdi_pkg::SAMPLE_W-1], r_prev_s};
    assign e_val  = $signed({r_prev_s, {sfdi_pkg::FRAC_W{1'b0}}})
                    + $signed(wet_prod[sfdi_pkg::MCAND_W-1:0]);

    assign wet_mcand  = (r_state == S_LOAD_I)
                        ? {{(sfdi_pkg::MCAND_W - sfdi_pkg::SAMPLE_W - 1){diff[sfdi_pkg::SAMPLE_W]}},
                           diff}
                        : e_val;
    assign wet_mplier = (r_state == S_LOAD_I)
                        ? {{(sfdi_pkg::MPLIER_W - sfdi_pkg::FRAC_W){1'b0}}, r_frac}
                        : r_wet;
    assign dry_mcand  = {r_x, {sfdi_pkg::FRAC_W{1'b0}}};

    assign ctl_wet.load = (r_state == S_LOAD_I) || (r_state == S_LOAD_G);
    assign ctl_wet.step = (r_state == S_MUL_I) || (r_state == S_MUL_G);
    assign ctl_fb.load  = (r_state == S_LOAD_G);
    assign ctl_fb.step  = (r_state == S_MUL_G);
    assign ctl_dry.load = (r_state == S_LOAD_G);
    assign ctl_dry.step = (r_state == S_MUL_G);

    sfdi_smul u_fb (
        .i_clk     (i_clk),
        .i_ctl     (ctl_fb),
        .i_mcand   (e_val),
        .i_mplier  (fb_capped),
        .o_product (fb_prod)
    );

    sfdi_smul u_dry (
        .i_clk     (i_clk),
        .i_ctl     (ctl_dry),
        .i_mcand   (dry_mcand),
        .i_mplier  (r_dry),
        .o_product (dry_prod)
    );

    sfdi_smul u_wet (
        .i_clk     (i_clk),
        .i_ctl     (ctl_wet),
        .i_mcand   (wet_mcand),
        .i_mplier  (wet_mplier),
        .o_product (wet_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if ((r_state == S_LOAD_I) || (r_state == S_LOAD_G)) begin
            r_cnt <= '0;
        end else if ((r_state == S_MUL_I) || (r_state == S_MUL_G)) begin
            r_cnt <= r_cnt + sfdi_pkg::CNT_W'(1);
        end
    end

    assign fb_round  = fb_prod + sfdi_pkg::PROD_W'(48'sd8388608);
    assign fb_term   = fb_round[sfdi_pkg::PROD_W-1:24];
    assign store_sum = 28'(r_x) + 28'(fb_term);
    assign store_val = sat24(store_sum);
    assign acc_sum   = {dry_prod[sfdi_pkg::PROD_W-1], dry_prod}
                       + {wet_prod[sfdi_pkg::PROD_W-1], wet_prod}
                       + (sfdi_pkg::PROD_W + 1)'(49'sd1048576);

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_y <= sat24(acc_sum[sfdi_pkg::PROD_W:21]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_wrap <= '0;
        end else if (wr_en) begin
            r_wp[r_line] <= r_wp[r_line] + sfdi_pkg::DELAY_AW'(1);
            if (&r_wp[r_line]) begin
                r_wrap[r_line] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_OUT) && slot_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && slot_free) begin
            r_out_data <= r_y;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item was in flight");

    a_gain_pass_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL_G) && (r_cnt == CNT_LAST)) |=> (r_state == S_FIN))
        else $error("gain multiply pass did not end after its last bit");

    a_pointer_moves_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> $stable(r_wp))
        else $error("write pointer moved outside the write-back step");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && m_axis_tvalid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("finished item dropped while the output was stalled");

endmodule

// ===== rtl/sfdi_smul.sv =====
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
// One multiplier bit per cycle while step is high, LSB first; uses sfdi_pkg.
module sfdi_smul (
    input  logic                                i_clk,
    input  sfdi_pkg::t_mul_ctl                  i_ctl,
    input  logic signed [sfdi_pkg::MCAND_W-1:0] i_mcand,
    input  logic [sfdi_pkg::MPLIER_W-1:0]       i_mplier,
    output logic signed [sfdi_pkg::PROD_W-1:0]  o_product
);

    logic signed [sfdi_pkg::MCAND_W:0]   r_hi;
    logic [sfdi_pkg::MPLIER_W-1:0]       r_lo;
    logic signed [sfdi_pkg::MCAND_W-1:0] r_mcand;
    logic [sfdi_pkg::MPLIER_W-1:0]       r_mplier;
    logic signed [sfdi_pkg::MCAND_W:0]   sum;

    assign sum = r_hi + (r_mplier[0] ? {r_mcand[sfdi_pkg::MCAND_W-1], r_mcand}
                                     : {(sfdi_pkg::MCAND_W + 1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hi     <= '0;
            r_lo     <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (i_ctl.step) begin
            r_hi     <= {sum[sfdi_pkg::MCAND_W], sum[sfdi_pkg::MCAND_W:1]};
            r_lo     <= {sum[0], r_lo[sfdi_pkg::MPLIER_W-1:1]};
            r_mplier <= {1'b0, r_mplier[sfdi_pkg::MPLIER_W-1:1]};
        end
    end

    assign o_product = {r_hi[sfdi_pkg::MCAND_W-1:0], r_lo};

endmodule

// ===== tb/sfdi_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stereo feedback delay: watches the sample, result and register channels,
// predicts every result from its own copy of the delay lines and settings, and compares.
// Depends on sfdi_pkg for widths, the feedback cap, register defaults and register indexes.
module sfdi_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_valid,
    input  logic                          i_s_ready,
    input  logic [sfdi_pkg::SAMPLE_W-1:0] i_s_data,
    input  logic [sfdi_pkg::CH_W-1:0]     i_s_user,
    input  logic                          i_m_valid,
    input  logic                          i_m_ready,
    input  logic [sfdi_pkg::SAMPLE_W-1:0] i_m_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [sfdi_pkg::DELAY_W-1:0]  i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count,
    output int                            o_checked
);
    import sfdi_pkg::*;

    bit   [SAMPLE_W-1:0] echo_line [0:1][0:MAX_DELAY-1];
    bit   [DELAY_AW-1:0] write_ptr [0:1];
    logic [DELAY_W-1:0]  delay_reg;
    logic [GAIN_W-1:0]   feedback_reg;
    logic [GAIN_W-1:0]   dry_reg;
    logic [GAIN_W-1:0]   wet_reg;
    logic [SAMPLE_W-1:0] owed_samples [$];
    logic [SAMPLE_W-1:0] want;
    int                  fail_total = 0;
    int                  checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;

    function automatic longint signed round_shr(longint signed v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp24(longint signed v);
        if (v > 64'sd8388607) return 24'h7FFFFF;
        if (v < -64'sd8388608) return 24'h800000;
        return v[SAMPLE_W-1:0];
    endfunction

    // Computes the output for one sample and, for channels 0 and 1, updates the line of its channel.
    function automatic logic [SAMPLE_W-1:0] echo_mix(logic [CH_W-1:0] ch,
                                                     logic [SAMPLE_W-1:0] raw);
        longint signed x, e, acc, stored, prev_v, next_v, r;
        logic [DELAY_AW-1:0] rd_prev, rd_next, wr;
        logic [FRAC_W-1:0]   frac;
        logic [GAIN_W-1:0]   fb;
        int                  side;
        x = longint'(signed'(raw));
        if (ch > 1) return clamp24(round_shr(x * longint'(dry_reg), 13));
        side    = ch[0];
        frac    = delay_reg[FRAC_W-1:0];
        r       = (frac != 0) ? 256 - longint'(frac) : 0;
        wr      = write_ptr[side];
        // A nonzero fraction floors the read position one entry further back.
        rd_prev = wr - delay_reg[DELAY_W-1:FRAC_W] - (frac != 0);
        rd_next = rd_prev + 1'b1;
        prev_v  = longint'(signed'(echo_line[side][rd_prev]));
        next_v  = longint'(signed'(echo_line[side][rd_next]));
        e       = prev_v * (256 - r) + next_v * r;
        fb      = (feedback_reg > FEEDBACK_CAP) ? FEEDBACK_CAP : feedback_reg;
        stored  = x + round_shr(e * longint'(fb), 24);
        acc     = x * longint'(dry_reg) * 256 + e * longint'(wet_reg);
        echo_line[side][wr] = clamp24(stored);
        write_ptr[side] = wr + 1'b1;
        return clamp24(round_shr(acc, 21));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            write_ptr[0] = '0;
            write_ptr[1] = '0;
            delay_reg    = DELAY_RESET;
            feedback_reg = FEEDBACK_RESET;
            dry_reg      = DRY_RESET;
            wet_reg      = WET_RESET;
            owed_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELAY:    delay_reg    = i_cfg_data;
                    CFG_FEEDBACK: feedback_reg = i_cfg_data[GAIN_W-1:0];
                    CFG_DRY:      dry_reg      = i_cfg_data[GAIN_W-1:0];
                    CFG_WET:      wet_reg      = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                if (owed_samples.size() == 0) begin
                    fail_total++;
                    $display("%0t: result %h arrived with no sample outstanding",
                             $time, i_m_data);
                end else begin
                    want = owed_samples.pop_front();
                    checked_total++;
                    if (want !== i_m_data) begin
                        fail_total++;
                        $display("%0t: sample_out expected %h (%0d) actual %h (%0d)",
                                 $time, want, signed'(want), i_m_data,
                                 signed'(i_m_data));
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                owed_samples.push_back(echo_mix(i_s_user, i_s_data));
        end
        o_pending <= owed_samples.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the stereo feedback delay testbench: clock, reset, sample and register stimulus,
// result back-pressure, watchdog and verdict. Depends on sfdi_pkg, sfdi_checker and the block.
module tb;
    import sfdi_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 12;
    localparam int RAND_ITEMS     = 136;
    localparam int TAIL_CYCLES    = 50;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;
    logic [CH_W-1:0]     s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index   = '0;
    logic [DELAY_W-1:0]  i_cfg_data    = '0;

    int pending;
    int fail_count;
    int checked;
    int sent_items    = 0;
    int setting_loads = 0;
    int idle_cycles   = 0;
    int stall_left    = 0;
    bit calm          = 1'b0;

    stereo_feedback_delay_interp u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sfdi_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_user     (s_axis_tuser),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return SAMPLE_W'($urandom_range(0, 511) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= ch;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // Stops the sample stream and waits until every result has been taken.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DELAY_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Gain words carry random upper bits, which the block must drop.
    task automatic load_settings(input logic [DELAY_W-1:0] dly, input logic [GAIN_W-1:0] fb,
                                 input logic [GAIN_W-1:0] dry, input logic [GAIN_W-1:0] wet);
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_FEEDBACK, {11'($urandom), fb});
        write_reg(CFG_DRY, {11'($urandom), dry});
        write_reg(CFG_WET, {11'($urandom), wet});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        setting_loads++;
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 4))
            0: return 16'd8192;
            1: return 16'hFFFF;
            2: return 16'd0;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic random_settings();
        logic [DELAY_W-1:0] dly;
        logic [GAIN_W-1:0]  fb;
        case ($urandom_range(0, 5))
            0: dly = DELAY_W'($urandom_range(0, 4 * 256));
            1, 2: dly = DELAY_W'($urandom_range(0, 150 * 256));
            3: dly = {19'($urandom_range(1, 120)), 8'h00};
            4: dly = DELAY_W'($urandom);
            default: dly = '1;
        endcase
        case ($urandom_range(0, 3))
            0: fb = '0;
            1: fb = FEEDBACK_CAP;
            2: fb = GAIN_W'($urandom_range(FEEDBACK_CAP + 1, 65535));
            default: fb = GAIN_W'($urandom);
        endcase
        load_settings(dly, fb, rand_gain(), rand_gain());
    endtask

    // Mostly ordered frames starting at the left channel, with some stray channels mixed in.
    task automatic play_phase(input int n_items);
        int done;
        int frame_len;
        int k;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                push_sample(CH_W'($urandom_range(0, 7)), rand_sample());
                done++;
            end else begin
                frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 8) : 2;
                for (k = 0; k < frame_len; k++) push_sample(k[CH_W-1:0], rand_sample());
                done += frame_len;
            end
        end
    endtask

    initial begin
        int phase;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_sample(3'd0, 24'h7FFFFF);
        push_sample(3'd0, 24'h800000);
        push_sample(3'd1, 24'h7FFFFF);
        push_sample(3'd1, 24'h800000);
        push_sample(3'd2, 24'h7FFFFF);
        push_sample(3'd3, 24'h800000);
        push_sample(3'd7, 24'h000001);
        push_sample(3'd5, 24'hFFFFFF);

        // Half-sample delay, feedback above its cap and the largest gains.
        settle();
        load_settings(27'h80, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (3) push_sample(3'd0, 24'h7FFFFF);
        repeat (3) push_sample(3'd1, 24'h800000);
        push_sample(3'd6, 24'h7FFFFF);
        push_sample(3'd4, 24'h800000);

        // Zero delay reads the entry about to be overwritten; all gains zero.
        settle();
        load_settings('0, '0, '0, '0);
        push_sample(3'd0, 24'h123456);
        push_sample(3'd1, 24'hABCDEF);
        push_sample(3'd2, 24'h7FFFFF);

        // Largest delay word, feedback exactly at the cap.
        settle();
        load_settings('1, FEEDBACK_CAP, 16'd8192, 16'hFFFF);
        push_sample(3'd0, 24'h7FFFFF);
        push_sample(3'd1, 24'h800000);
        push_sample(3'd0, 24'h000000);
        push_sample(3'd1, 24'h400000);

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            calm = (phase == RAND_PHASES - 1);
            random_settings();
            play_phase(RAND_ITEMS);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples over %0d register settings; %0d results compared.",
                 sent_items, setting_loads, checked);
        $display("Channels 0 to 7, delays up to the full word, feedback around its cap.");
        if (pending != 0) $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sfdi_pkg.sv
rtl/sfdi_smul.sv
rtl/stereo_feedback_delay_interp.sv
tb/sfdi_checker.sv
tb/tb.sv
